// ===== design/odr_pkg.sv =====
// ----------------------------------------------------------------------------
// odr_pkg
// Shared widths, register codes, the CORDIC arctangent table and the
// saturation helpers for the dead-reckoning odometry block.
// ----------------------------------------------------------------------------
package odr_pkg;

  // Sample and result field widths.
  localparam int DIST_W = 32;
  localparam int ANG_W  = 16;
  localparam int VEL_W  = 16;
  localparam int POS_W  = 32;

  // Limit register widths and reset values.
  localparam int DLIM_W = 31;
  localparam int VLIM_W = 15;
  localparam logic [DLIM_W-1:0] DLIM_RST = 31'd78643;
  localparam logic [VLIM_W-1:0] TLIM_RST = 15'd4096;
  localparam logic [VLIM_W-1:0] RLIM_RST = 15'd4096;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST_LIM = 2'd0,
    CFG_TVEL_LIM = 2'd1,
    CFG_RVEL_LIM = 2'd2
  } cfg_idx_e;

  // CORDIC: Q2.30 vectors with headroom, angles scaled so that 2^32 is a turn.
  localparam int CORDIC_STEPS = 16;
  localparam int CRD_W        = 34;
  localparam int Z_W          = 33;
  localparam int ATAN_IDX_W   = 5;
  localparam logic signed [CRD_W-1:0] CRD_GAIN = 34'sd652032874;

  // Multiply unit: 33-bit signed operand times a CORDIC output, Q30 fraction rounded off the result.
  localparam int MAC_A_W   = DIST_W + 1;
  localparam int MAC_B_W   = CRD_W;
  localparam int MAC_ACC_W = MAC_A_W + MAC_B_W + 1;
  localparam int MAC_FRAC  = 30;
  localparam int MAC_RES_W = MAC_ACC_W - MAC_FRAC;
  localparam logic signed [MAC_ACC_W-1:0] MAC_ROUND = MAC_ACC_W'(64'd536870912);

  // Width of the position plus update sum before saturation.
  localparam int POS_SUM_W = MAC_RES_W + 1;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [29:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:    val = 30'd536870912;
      5'd1:    val = 30'd316933406;
      5'd2:    val = 30'd167458907;
      5'd3:    val = 30'd85004756;
      5'd4:    val = 30'd42667331;
      5'd5:    val = 30'd21354465;
      5'd6:    val = 30'd10679838;
      5'd7:    val = 30'd5340245;
      5'd8:    val = 30'd2670163;
      5'd9:    val = 30'd1335087;
      5'd10:   val = 30'd667544;
      5'd11:   val = 30'd333772;
      5'd12:   val = 30'd166886;
      5'd13:   val = 30'd83443;
      5'd14:   val = 30'd41722;
      5'd15:   val = 30'd20861;
      5'd16:   val = 30'd10430;
      5'd17:   val = 30'd5215;
      5'd18:   val = 30'd2608;
      5'd19:   val = 30'd1304;
      5'd20:   val = 30'd652;
      5'd21:   val = 30'd326;
      5'd22:   val = 30'd163;
      5'd23:   val = 30'd81;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

  // Clamp a position sum to the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] sat_pos(
    input logic signed [POS_SUM_W-1:0] v
  );
    logic [POS_SUM_W-POS_W:0] top;
    top = v[POS_SUM_W-1:POS_W-1];
    if (&top || ~|top) begin
      return v[POS_W-1:0];
    end
    return v[POS_SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  // Clamp a product to the signed 16-bit velocity range.
  function automatic logic signed [VEL_W-1:0] sat_vel(
    input logic signed [MAC_RES_W-1:0] v
  );
    logic [MAC_RES_W-VEL_W:0] top;
    top = v[MAC_RES_W-1:VEL_W-1];
    if (&top || ~|top) begin
      return v[VEL_W-1:0];
    end
    return v[MAC_RES_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
  endfunction

endpackage

// ===== design/odometry_dead_reckoning.sv =====
// ----------------------------------------------------------------------------
// odometry_dead_reckoning
// Dead-reckoning pose and velocity from cumulative distance and bearing
// samples, with jump rejection on distance and on both velocities.
//
//   Channel   Handshake              Payload
//   input     in_valid_i/in_ready_o  distance_in, bearing_in, tvel_in, rvel_in
//   result    out_valid_o/out_ready_i pose, yaw, velocities, validity flags
//   config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample reaches the output register through the check, the CORDIC start,
// one micro-rotation per cycle, done, four products on the shared multiplier
// and the load. The input is ready again the cycle after the load; a sample
// rejected for its distance step goes from the check straight to the load.
// A finished sample that finds the last result still waiting holds the input
// not ready until that result moves on. All state, including the limits,
// comes out of reset set.
// ----------------------------------------------------------------------------
module odometry_dead_reckoning (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [odr_pkg::DIST_W-1:0]      distance_in_i,
  input  logic signed [odr_pkg::ANG_W-1:0]       bearing_in_i,
  input  logic signed [odr_pkg::VEL_W-1:0]       tvel_in_i,
  input  logic signed [odr_pkg::VEL_W-1:0]       rvel_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   pose_valid_o,
  output logic signed [odr_pkg::POS_W-1:0]       x_pos_o,
  output logic signed [odr_pkg::POS_W-1:0]       y_pos_o,
  output logic signed [odr_pkg::ANG_W-1:0]       yaw_out_o,
  output logic                                   odom_valid_o,
  output logic signed [odr_pkg::VEL_W-1:0]       vel_x_o,
  output logic signed [odr_pkg::VEL_W-1:0]       vel_y_o,
  output logic signed [odr_pkg::VEL_W-1:0]       rot_vel_out_o,
  output logic signed [odr_pkg::ANG_W-1:0]       abs_heading_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [odr_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [odr_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import odr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CORDIC,
    S_MUL,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    OP_PX,
    OP_PY,
    OP_VX,
    OP_VY
  } mul_op_e;

  state_e  state_q, state_d;
  mul_op_e op_q, op_d;

  // Latched sample.
  logic signed [DIST_W-1:0] dist_q, dist_d;
  logic signed [ANG_W-1:0]  brg_q, brg_d;
  logic signed [VEL_W-1:0]  tv_q, tv_d, rv_q, rv_d;

  // Odometry state.
  logic                     started_q, started_d;
  logic signed [ANG_W-1:0]  ref_q, ref_d, prel_q, prel_d, head_q, head_d;
  logic signed [DIST_W-1:0] pdist_q, pdist_d;
  logic signed [POS_W-1:0]  posx_q, posx_d, posy_q, posy_d;
  logic signed [VEL_W-1:0]  ptv_q, ptv_d, prv_q, prv_d;

  // Limits.
  logic [DLIM_W-1:0] dlim_q, dlim_d;
  logic [VLIM_W-1:0] tlim_q, tlim_d, rlim_q, rlim_d;

  // Per-sample work registers.
  logic                      pv_q, pv_d, ov_q, ov_d;
  logic signed [MAC_A_W-1:0] dd_q, dd_d;
  logic signed [VEL_W-1:0]   velx_q, velx_d, vely_q, vely_d;
  logic                      crd_start_q, crd_start_d, mac_start_q, mac_start_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic                     o_pv_q, o_pv_d, o_ov_q, o_ov_d;
  logic signed [POS_W-1:0]  o_x_q, o_x_d, o_y_q, o_y_d;
  logic signed [ANG_W-1:0]  o_yaw_q, o_yaw_d, o_absh_q, o_absh_d;
  logic signed [VEL_W-1:0]  o_vx_q, o_vx_d, o_vy_q, o_vy_d, o_rv_q, o_rv_d;

  // Check-cycle arithmetic.
  logic signed [MAC_A_W-1:0] dd;
  logic [MAC_A_W-1:0]        dd_mag;
  logic signed [VEL_W:0]     dtv, drv;
  logic [VEL_W:0]            dtv_mag, drv_mag;
  logic signed [ANG_W-1:0]   rel;
  logic                      dist_jump, tv_ok, rv_ok, pose_ok;

  // Shared units.
  logic                        crd_done, mac_done;
  logic signed [CRD_W-1:0]     cos_v, sin_v;
  logic signed [MAC_A_W-1:0]   mac_a;
  logic signed [MAC_B_W-1:0]   mac_b;
  logic signed [MAC_RES_W-1:0] mac_res;
  logic signed [POS_SUM_W-1:0] posx_sum, posy_sum;

  assign dd        = {dist_q[DIST_W-1], dist_q} - {pdist_q[DIST_W-1], pdist_q};
  assign dd_mag    = dd[MAC_A_W-1] ? -dd : dd;
  assign dist_jump = dd_mag > {2'b00, dlim_q};
  assign rel       = brg_q - ref_q;
  assign dtv       = {tv_q[VEL_W-1], tv_q} - {ptv_q[VEL_W-1], ptv_q};
  assign drv       = {rv_q[VEL_W-1], rv_q} - {prv_q[VEL_W-1], prv_q};
  assign dtv_mag   = dtv[VEL_W] ? -dtv : dtv;
  assign drv_mag   = drv[VEL_W] ? -drv : drv;
  assign tv_ok     = dtv_mag <= {2'b00, tlim_q};
  assign rv_ok     = drv_mag <= {2'b00, rlim_q};
  assign pose_ok   = !started_q || !dist_jump;

  assign mac_a = (op_q == OP_PX || op_q == OP_PY) ? dd_q : MAC_A_W'(tv_q);
  assign mac_b = (op_q == OP_PX || op_q == OP_VX) ? cos_v : sin_v;

  assign posx_sum = POS_SUM_W'(posx_q) + POS_SUM_W'(mac_res);
  assign posy_sum = POS_SUM_W'(posy_q) + POS_SUM_W'(mac_res);

  odr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crd_start_q),
    .angle_i (head_q),
    .done_o  (crd_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  odr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start_q),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    dist_d      = dist_q;
    brg_d       = brg_q;
    tv_d        = tv_q;
    rv_d        = rv_q;
    started_d   = started_q;
    ref_d       = ref_q;
    prel_d      = prel_q;
    head_d      = head_q;
    pdist_d     = pdist_q;
    posx_d      = posx_q;
    posy_d      = posy_q;
    ptv_d       = ptv_q;
    prv_d       = prv_q;
    dlim_d      = dlim_q;
    tlim_d      = tlim_q;
    rlim_d      = rlim_q;
    pv_d        = pv_q;
    ov_d        = ov_q;
    dd_d        = dd_q;
    velx_d      = velx_q;
    vely_d      = vely_q;
    crd_start_d = 1'b0;
    mac_start_d = 1'b0;
    out_valid_d = out_valid_q;
    o_pv_d      = o_pv_q;
    o_ov_d      = o_ov_q;
    o_x_d       = o_x_q;
    o_y_d       = o_y_q;
    o_yaw_d     = o_yaw_q;
    o_absh_d    = o_absh_q;
    o_vx_d      = o_vx_q;
    o_vy_d      = o_vy_q;
    o_rv_d      = o_rv_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DIST_LIM) begin
        dlim_d = cfg_data_i[DLIM_W-1:0];
      end else if (cfg_index_i == CFG_TVEL_LIM) begin
        tlim_d = cfg_data_i[VLIM_W-1:0];
      end else if (cfg_index_i == CFG_RVEL_LIM) begin
        rlim_d = cfg_data_i[VLIM_W-1:0];
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dist_d  = distance_in_i;
          brg_d   = bearing_in_i;
          tv_d    = tvel_in_i;
          rv_d    = rvel_in_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // The first sample sets the reference and runs with a zero step.
        if (!started_q) begin
          started_d = 1'b1;
          ref_d     = brg_q;
          posx_d    = '0;
          posy_d    = '0;
          head_d    = '0;
          pdist_d   = dist_q;
          prel_d    = '0;
          dd_d      = '0;
        end else if (!dist_jump) begin
          head_d  = head_q + rel - prel_q;
          pdist_d = dist_q;
          prel_d  = rel;
          dd_d    = dd;
        end
        ov_d = 1'b0;
        if (pose_ok && tv_ok) begin
          ptv_d = tv_q;
          if (rv_ok) begin
            prv_d = rv_q;
            ov_d  = 1'b1;
          end
        end
        pv_d = pose_ok;
        if (pose_ok) begin
          crd_start_d = 1'b1;
          state_d     = S_CORDIC;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CORDIC: begin
        if (crd_done) begin
          op_d        = OP_PX;
          mac_start_d = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        if (mac_done) begin
          case (op_q)
            OP_PX:   posx_d = sat_pos(posx_sum);
            OP_PY:   posy_d = sat_pos(posy_sum);
            OP_VX:   velx_d = sat_vel(mac_res);
            OP_VY:   vely_d = sat_vel(mac_res);
            default: velx_d = velx_q;
          endcase
          if (op_q == OP_VY) begin
            state_d = S_FIN;
          end else begin
            op_d        = mul_op_e'(op_q + 1'b1);
            mac_start_d = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_pv_d      = pv_q;
          o_ov_d      = ov_q;
          o_x_d       = posx_q;
          o_y_d       = posy_q;
          o_yaw_d     = prel_q;
          o_vx_d      = ov_q ? velx_q : '0;
          o_vy_d      = ov_q ? vely_q : '0;
          o_rv_d      = ov_q ? rv_q : '0;
          o_absh_d    = ov_q ? brg_q : '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_PX;
      dist_q      <= '0;
      brg_q       <= '0;
      tv_q        <= '0;
      rv_q        <= '0;
      started_q   <= 1'b0;
      ref_q       <= '0;
      prel_q      <= '0;
      head_q      <= '0;
      pdist_q     <= '0;
      posx_q      <= '0;
      posy_q      <= '0;
      ptv_q       <= '0;
      prv_q       <= '0;
      dlim_q      <= DLIM_RST;
      tlim_q      <= TLIM_RST;
      rlim_q      <= RLIM_RST;
      pv_q        <= 1'b0;
      ov_q        <= 1'b0;
      dd_q        <= '0;
      velx_q      <= '0;
      vely_q      <= '0;
      crd_start_q <= 1'b0;
      mac_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      o_pv_q      <= 1'b0;
      o_ov_q      <= 1'b0;
      o_x_q       <= '0;
      o_y_q       <= '0;
      o_yaw_q     <= '0;
      o_absh_q    <= '0;
      o_vx_q      <= '0;
      o_vy_q      <= '0;
      o_rv_q      <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      dist_q      <= dist_d;
      brg_q       <= brg_d;
      tv_q        <= tv_d;
      rv_q        <= rv_d;
      started_q   <= started_d;
      ref_q       <= ref_d;
      prel_q      <= prel_d;
      head_q      <= head_d;
      pdist_q     <= pdist_d;
      posx_q      <= posx_d;
      posy_q      <= posy_d;
      ptv_q       <= ptv_d;
      prv_q       <= prv_d;
      dlim_q      <= dlim_d;
      tlim_q      <= tlim_d;
      rlim_q      <= rlim_d;
      pv_q        <= pv_d;
      ov_q        <= ov_d;
      dd_q        <= dd_d;
      velx_q      <= velx_d;
      vely_q      <= vely_d;
      crd_start_q <= crd_start_d;
      mac_start_q <= mac_start_d;
      out_valid_q <= out_valid_d;
      o_pv_q      <= o_pv_d;
      o_ov_q      <= o_ov_d;
      o_x_q       <= o_x_d;
      o_y_q       <= o_y_d;
      o_yaw_q     <= o_yaw_d;
      o_absh_q    <= o_absh_d;
      o_vx_q      <= o_vx_d;
      o_vy_q      <= o_vy_d;
      o_rv_q      <= o_rv_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign pose_valid_o  = o_pv_q;
  assign x_pos_o       = o_x_q;
  assign y_pos_o       = o_y_q;
  assign yaw_out_o     = o_yaw_q;
  assign odom_valid_o  = o_ov_q;
  assign vel_x_o       = o_vx_q;
  assign vel_y_o       = o_vy_q;
  assign rot_vel_out_o = o_rv_q;
  assign abs_heading_o = o_absh_q;

endmodule

// ===== design/odr_cordic.sv =====
// ----------------------------------------------------------------------------
// odr_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle through a
// single shift-add datapath, giving cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module odr_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [odr_pkg::ANG_W-1:0]    angle_i,
  output logic                                done_o,
  output logic signed [odr_pkg::CRD_W-1:0]    cos_o,
  output logic signed [odr_pkg::CRD_W-1:0]    sin_o
);
  import odr_pkg::*;

  localparam logic [ATAN_IDX_W-1:0] CNT_LAST = ATAN_IDX_W'(CORDIC_STEPS - 1);
  localparam logic signed [ANG_W:0] QUARTER  = 17'sd16384;
  localparam logic signed [ANG_W:0] HALF     = 17'sd32768;

  logic signed [CRD_W-1:0]  x_q, x_d, y_q, y_d, dx, dy;
  logic signed [Z_W-1:0]    z_q, z_d, at;
  logic [ATAN_IDX_W-1:0]    cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic signed [ANG_W:0]    ang_ext, ang_fold;
  logic                     fold;

  // Angles past a quarter turn are folded by a half turn; the result is negated.
  always_comb begin
    ang_ext = {angle_i[ANG_W-1], angle_i};
    fold    = 1'b1;
    if (ang_ext > QUARTER) begin
      ang_fold = ang_ext - HALF;
    end else if (ang_ext < -QUARTER) begin
      ang_fold = ang_ext + HALF;
    end else begin
      ang_fold = ang_ext;
      fold     = 1'b0;
    end
  end

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = {3'b000, atan_lut(cnt_q)};

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = CRD_GAIN;
      y_d    = '0;
      z_d    = {ang_fold, 16'h0000};
      cnt_d  = '0;
      busy_d = 1'b1;
      neg_d  = fold;
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      neg_q  <= neg_d;
    end
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule

// ===== design/odr_mac.sv =====
// ----------------------------------------------------------------------------
// odr_mac
// Two-pass multiplier: a 33-bit operand times a CORDIC output, one slice of the
// first operand per cycle (low 16 bits, then top 17 bits), rounded half up at bit 30.
// ----------------------------------------------------------------------------
module odr_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [odr_pkg::MAC_A_W-1:0]    a_i,
  input  logic signed [odr_pkg::MAC_B_W-1:0]    b_i,
  output logic                                  done_o,
  output logic signed [odr_pkg::MAC_RES_W-1:0]  res_o
);
  import odr_pkg::*;

  localparam int SLICE_W = 16;
  localparam int PROD_W  = SLICE_W + 1 + MAC_B_W;

  logic signed [MAC_ACC_W-1:0] acc_q, acc_d, addend;
  logic signed [SLICE_W:0]     mop;
  logic signed [PROD_W-1:0]    prod;
  logic                        phase_q, phase_d, done_q, done_d;

  // The low slice goes in unsigned on the first pass, the signed top slice second.
  assign mop  = phase_q ? a_i[MAC_A_W-1:SLICE_W] : {1'b0, a_i[SLICE_W-1:0]};
  assign prod = mop * b_i;

  always_comb begin
    addend = MAC_ACC_W'(prod);
    if (phase_q) begin
      addend = addend <<< SLICE_W;
    end
  end

  always_comb begin
    acc_d   = acc_q;
    phase_d = 1'b0;
    done_d  = 1'b0;
    if (start_i) begin
      acc_d   = MAC_ROUND + addend;
      phase_d = 1'b1;
    end else if (phase_q) begin
      acc_d  = acc_q + addend;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q[MAC_ACC_W-1:MAC_FRAC];

endmodule

// ===== design/odr_chk.sv =====
// ----------------------------------------------------------------------------
// odr_chk
// Port-level checks for the odometry block, bound to its top level.
// ----------------------------------------------------------------------------
module odr_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              pose_valid_o,
  input logic signed [odr_pkg::POS_W-1:0]  x_pos_o,
  input logic signed [odr_pkg::ANG_W-1:0]  yaw_out_o,
  input logic                              odom_valid_o,
  input logic signed [odr_pkg::VEL_W-1:0]  vel_x_o,
  input logic signed [odr_pkg::VEL_W-1:0]  vel_y_o,
  input logic signed [odr_pkg::VEL_W-1:0]  rot_vel_out_o,
  input logic signed [odr_pkg::ANG_W-1:0]  abs_heading_o
);
  import odr_pkg::*;

  // A stalled result holds its x position and yaw.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_pos_o) && $stable(yaw_out_o))
    else $error("result changed while stalled");

  // After a transaction on the input the block is busy with that sample.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transaction");

  // A rejected pose never carries valid velocities.
  a_pose_odom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pose_valid_o |-> !odom_valid_o)
    else $error("odometry valid on a rejected pose");

  // Velocity fields and the absolute heading are zero whenever the velocity checks failed.
  a_vel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !odom_valid_o |-> vel_x_o == '0 && vel_y_o == '0 &&
      rot_vel_out_o == '0 && abs_heading_o == '0)
    else $error("velocity fields set without odometry valid");

endmodule

bind odometry_dead_reckoning odr_chk u_odr_chk (.*);
